// ===== src/frame_aligned_sample_fifo_macros.svh =====
// Assertion macros used by the checker file of the sample ring.
`ifndef FRAME_ALIGNED_SAMPLE_FIFO_MACROS_SVH
`define FRAME_ALIGNED_SAMPLE_FIFO_MACROS_SVH

// Implication within the same clock edge.
`define FASF_SAME(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fasf checker: same-cycle rule violated");

// Implication into the next clock edge.
`define FASF_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fasf checker: next-cycle rule violated");

`endif

// ===== src/fasf_pkg.sv =====
// Shared types, codes and constants of the frame-aligned sample ring.
`default_nettype none
package fasf_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;
  localparam int MAX_FRAME_DEF = 16;

  localparam int CNT_W      = 7;
  localparam int FRAME_W    = 5;
  localparam int FILL_W     = 10;
  localparam int WORD_W     = 32;
  localparam int ADDR_MAX_W = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] OP_WR_REQ = 3'd0;
  localparam logic [2:0] OP_WR_SMP = 3'd1;
  localparam logic [2:0] OP_RD_REQ = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic REG_FRAME_SIZE = 1'b0;

  typedef enum logic [1:0] {
    F_IDLE,
    F_EVAL,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_STREAM
  } back_state_t;

  typedef enum logic [1:0] {
    Q_PLAIN,
    Q_WRITE,
    Q_READ
  } qkind_t;

  typedef struct packed {
    qkind_t                  kind;
    logic [CNT_W-1:0]        granted;
    logic [ADDR_MAX_W-1:0]   addr;
    logic [WORD_W-1:0]       data;
    logic [FILL_W-1:0]       fill;
    logic                    flush;
  } fasf_cmd_t;

endpackage
`default_nettype wire

// ===== src/fasf_queue.sv =====
// Short command queue between the front and back parts.
`default_nettype none
module fasf_queue import fasf_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  fasf_cmd_t  push_cmd,
  input  wire        pop,
  output fasf_cmd_t  head,
  output logic       empty,
  output logic       full
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  fasf_cmd_t        slot_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  always_comb begin
    empty      = (count_r == '0);
    full       = (count_r == (QAW+1)'(QUEUE_DEPTH));
    head       = slot_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== src/fasf_front.sv =====
// Front part: accepts items, keeps the ring pointers and computes grants.
`default_nettype none
module fasf_front import fasf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF,
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         in_operation,
  input  wire  [CNT_W-1:0]   in_request_count,
  input  wire  [WORD_W-1:0]  in_sample_in,
  input  wire  [FRAME_W-1:0] frame_size,
  input  wire                q_full,
  output logic               q_push,
  output fasf_cmd_t          q_cmd
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (AW > CNT_W) ? AW : CNT_W;

  front_state_t       state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  smp_r, smp_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      rp_r, rp_nxt;
  logic               flush_r, flush_nxt;
  logic [CNT_W-1:0]   resv_r, resv_nxt;
  logic [CNT_W-1:0]   wcnt_r, wcnt_nxt;
  logic [CNT_W-1:0]   take_r, take_nxt;
  logic [5:0]         rem_r, rem_nxt;
  logic [2:0]         div_cnt_r, div_cnt_nxt;

  logic [AW-1:0]      fill;
  logic [AW-1:0]      limit;
  logic [AW-1:0]      fill_after;
  logic [FRAME_W-1:0] frame_eff;
  logic [CNT_W-1:0]   take_c;
  logic [CNT_W-1:0]   grant;
  logic [CNT_W-1:0]   wcnt_inc;
  logic [5:0]         rem_shift;
  logic               refused;
  logic               need_div;
  logic               accept;

  always_comb begin
    fill     = wp_r - rp_r;
    limit    = (op_r == OP_RD_REQ) ? fill : ({AW{1'b1}} - fill);
    take_c   = (CMPW'(limit) < CMPW'(cnt_r)) ? CNT_W'(limit) : cnt_r;
    if (frame_size == '0) begin
      frame_eff = FRAME_W'(1);
    end else if (int'(frame_size) > MAX_FRAME) begin
      frame_eff = FRAME_W'(MAX_FRAME);
    end else begin
      frame_eff = frame_size;
    end
    refused  = (resv_r != '0);
    need_div = ((op_r == OP_WR_REQ) || ((op_r == OP_RD_REQ) && !flush_r)) && !refused &&
               (take_c < cnt_r) && (frame_eff >= FRAME_W'(2));
    grant     = take_r - CNT_W'(rem_r);
    rem_shift = {rem_r[4:0], take_r[div_cnt_r]};
    wcnt_inc  = wcnt_r + 1'b1;
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cnt_nxt     = cnt_r;
    smp_nxt     = smp_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    flush_nxt   = flush_r;
    resv_nxt    = resv_r;
    wcnt_nxt    = wcnt_r;
    take_nxt    = take_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    q_push      = 1'b0;
    q_cmd.kind    = Q_PLAIN;
    q_cmd.granted = '0;
    q_cmd.addr    = '0;
    q_cmd.data    = smp_r;
    busy   = !((state_r == F_IDLE) || ((state_r == F_PUSH) && !q_full));
    accept = start && !busy;

    case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_EVAL;
      end
      F_EVAL: begin
        take_nxt    = take_c;
        rem_nxt     = '0;
        div_cnt_nxt = 3'(CNT_W - 1);
        state_nxt   = need_div ? F_DIV : F_PUSH;
      end
      F_DIV: begin
        rem_nxt     = (rem_shift >= 6'(frame_eff)) ? rem_shift - 6'(frame_eff) : rem_shift;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = accept ? F_EVAL : F_IDLE;
          case (op_r)
            OP_WR_REQ: begin
              if (!refused) begin
                resv_nxt      = grant;
                wcnt_nxt      = '0;
                q_cmd.granted = grant;
              end
            end
            OP_WR_SMP: begin
              if (refused) begin
                q_cmd.kind    = Q_WRITE;
                q_cmd.granted = resv_r;
                q_cmd.addr    = ADDR_MAX_W'(wp_r + AW'(wcnt_r));
                wcnt_nxt      = wcnt_inc;
                if (wcnt_inc >= resv_r) begin
                  wp_nxt   = wp_r + AW'(resv_r);
                  resv_nxt = '0;
                  wcnt_nxt = '0;
                end
              end
            end
            OP_RD_REQ: begin
              if (!refused) begin
                if (flush_r) begin
                  rp_nxt    = wp_r;
                  flush_nxt = 1'b0;
                end else if (grant != '0) begin
                  q_cmd.kind    = Q_READ;
                  q_cmd.granted = grant;
                  q_cmd.addr    = ADDR_MAX_W'(rp_r);
                  rp_nxt        = rp_r + AW'(grant);
                end
              end
            end
            OP_FLUSH: flush_nxt = 1'b1;
            OP_CLEAR: begin
              rp_nxt    = wp_r;
              flush_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = F_IDLE;
    endcase

    if (accept) begin
      op_nxt  = in_operation;
      cnt_nxt = (int'(in_request_count) > MAX_BURST) ? CNT_W'(MAX_BURST) : in_request_count;
      smp_nxt = in_sample_in;
    end

    fill_after  = wp_nxt - rp_nxt;
    q_cmd.fill  = FILL_W'(fill_after);
    q_cmd.flush = flush_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      flush_r <= 1'b0;
      resv_r  <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      flush_r <= flush_nxt;
      resv_r  <= resv_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    cnt_r     <= cnt_nxt;
    smp_r     <= smp_nxt;
    take_r    <= take_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

endmodule
`default_nettype wire

// ===== src/fasf_back.sv =====
// Back part: owns the sample memory, stores samples and streams results.
`default_nettype none
module fasf_back import fasf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_empty,
  input  fasf_cmd_t          q_head,
  output logic               q_pop,
  output logic               out_valid,
  output logic [CNT_W-1:0]   out_granted_count,
  output logic [WORD_W-1:0]  out_sample_out,
  output logic               out_last,
  output logic [FILL_W-1:0]  out_fill_level,
  output logic               out_flush_pending
);

  localparam int AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q_r;

  back_state_t       state_r, state_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  grant_r, grant_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              flh_r, flh_nxt;

  logic              valid_r, valid_nxt;
  logic              rd_r, rd_nxt;
  logic [CNT_W-1:0]  ogr_r, ogr_nxt;
  logic              olast_r, olast_nxt;
  logic [FILL_W-1:0] ofill_r, ofill_nxt;
  logic              oflh_r, oflh_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [CNT_W-1:0]  idx_inc;

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    grant_nxt = grant_r;
    fill_nxt  = fill_r;
    flh_nxt   = flh_r;
    valid_nxt = 1'b0;
    rd_nxt    = 1'b0;
    ogr_nxt   = ogr_r;
    olast_nxt = olast_r;
    ofill_nxt = ofill_r;
    oflh_nxt  = oflh_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = AW'(q_head.addr);
    mem_ra    = base_r + AW'(idx_r);
    idx_inc   = idx_r + 1'b1;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == Q_READ) begin
            state_nxt = B_STREAM;
            base_nxt  = AW'(q_head.addr);
            idx_nxt   = '0;
            grant_nxt = q_head.granted;
            fill_nxt  = q_head.fill;
            flh_nxt   = q_head.flush;
          end else begin
            mem_we    = (q_head.kind == Q_WRITE);
            valid_nxt = 1'b1;
            ogr_nxt   = q_head.granted;
            olast_nxt = 1'b1;
            ofill_nxt = q_head.fill;
            oflh_nxt  = q_head.flush;
          end
        end
      end
      B_STREAM: begin
        valid_nxt = 1'b1;
        rd_nxt    = 1'b1;
        ogr_nxt   = grant_r;
        olast_nxt = (idx_inc == grant_r);
        ofill_nxt = fill_r;
        oflh_nxt  = flh_r;
        idx_nxt   = idx_inc;
        if (idx_inc == grant_r) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= q_head.data;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      rd_r    <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    idx_r   <= idx_nxt;
    grant_r <= grant_nxt;
    fill_r  <= fill_nxt;
    flh_r   <= flh_nxt;
    ogr_r   <= ogr_nxt;
    olast_r <= olast_nxt;
    ofill_r <= ofill_nxt;
    oflh_r  <= oflh_nxt;
  end

  assign out_valid         = valid_r;
  assign out_granted_count = ogr_r;
  assign out_sample_out    = rd_r ? mem_q_r : '0;
  assign out_last          = olast_r;
  assign out_fill_level    = ofill_r;
  assign out_flush_pending = oflh_r;

endmodule
`default_nettype wire

// ===== src/frame_aligned_sample_fifo.sv =====
// Top level of the frame-aligned sample ring: configuration register and part wiring.
//
// Usage. Commands enter on the in_ ports and are taken at a rising edge where
// start is high and busy is low. A write request reserves room for up to
// in_request_count samples; the granted samples then follow as write-sample
// commands, one word each. A read request streams its granted words out on
// consecutive cycles with out_last on the final one. Every other command
// yields exactly one result word. Results appear on the out_ ports for one
// cycle each, marked by out_valid; the receiver cannot stall them.
// Timing. A command is evaluated in the cycle after it is taken (F_EVAL) and
// pushed into the command queue in F_PUSH, where busy is low unless the queue
// is full, so the next command can be taken while one is pushed; busy is high
// in between. A short grant that must be rounded down to whole frames adds the
// front's division step (F_DIV), one remainder bit per cycle. With the
// four-entry command queue empty and the back part idle, a first result passes
// the front states, the queue and the back part's output registers; a read
// stream adds B_STREAM and the registered memory read. A read streams one word
// per cycle from the sample memory; commands keep arriving into the queue
// meanwhile, and outside F_EVAL and F_DIV busy rises only when it is full.
// Reset. rst_n clears pointers, reservation, flush flag and frame_size (to 1);
// the sample memory is not cleared and needs no sweep.
`default_nettype none
module frame_aligned_sample_fifo import fasf_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF,
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         in_operation,
  input  wire  [CNT_W-1:0]   in_request_count,
  input  wire  [WORD_W-1:0]  in_sample_in,
  output logic               out_valid,
  output logic [CNT_W-1:0]   out_granted_count,
  output logic [WORD_W-1:0]  out_sample_out,
  output logic               out_last,
  output logic [FILL_W-1:0]  out_fill_level,
  output logic               out_flush_pending,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The only register is frame_size at byte address zero; paddr[2] is the
  // register index.
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               cfg_wr;

  fasf_cmd_t q_cmd, q_head;
  logic      q_push, q_pop, q_empty, q_full;

  always_comb begin
    pready    = 1'b1;
    cfg_wr    = psel && penable && pwrite;
    frame_nxt = (cfg_wr && (paddr[2] == REG_FRAME_SIZE)) ? pwdata[FRAME_W-1:0] : frame_r;
    prdata    = (paddr[2] == REG_FRAME_SIZE) ? 32'(frame_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= FRAME_W'(1);
    end else begin
      frame_r <= frame_nxt;
    end
  end

  // The front owns all pointer state, so commands are decided in order and
  // the queue only carries finished decisions to the back part.
  fasf_front #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST),
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_request_count (in_request_count),
    .in_sample_in     (in_sample_in),
    .frame_size       (frame_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  fasf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  fasf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_granted_count (out_granted_count),
    .out_sample_out    (out_sample_out),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level),
    .out_flush_pending (out_flush_pending)
  );

endmodule
`default_nettype wire

// ===== src/fasf_checker.sv =====
// Port-level checker for the sample ring, bound to the top level.
`default_nettype none
`include "frame_aligned_sample_fifo_macros.svh"
module fasf_checker import fasf_pkg::*; (
  input wire               clk,
  input wire               rst_n,
  input wire               start,
  input wire               busy,
  input wire               out_valid,
  input wire [CNT_W-1:0]   out_granted_count,
  input wire [WORD_W-1:0]  out_sample_out,
  input wire               out_last
);

  // A taken command always keeps the front occupied for its evaluation cycle.
  `FASF_NEXT(a_busy_after_take, clk, rst_n, start && !busy, busy)
  // A zero grant never starts a multi-word stream.
  `FASF_SAME(a_zero_grant_single, clk, rst_n, out_valid && (out_granted_count == '0), out_last)
  // Sample data shows only on a result word.
  `FASF_SAME(a_sample_only_valid, clk, rst_n, out_sample_out != '0, out_valid)
  // A read stream has no gaps before its last word.
  `FASF_NEXT(a_stream_contiguous, clk, rst_n, out_valid && !out_last, out_valid)

endmodule

bind frame_aligned_sample_fifo fasf_checker u_fasf_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the frame-aligned sample ring: commands, grants and read-out words.
module tb;
  import fasf_pkg::*;

  // The ring as configured in the block under test.
  localparam int RING_DEPTH = 1024;
  localparam int BURST_MAX  = 64;
  localparam int FRAME_MAX  = 16;
  localparam logic [2:0] OP_BAD = 3'd7;

  // One command word as it goes into the block.
  typedef struct packed {
    logic [2:0]        op;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] sample;
  } command_t;

  // One result word as the block should produce it.
  typedef struct packed {
    logic [CNT_W-1:0]  granted;
    logic [WORD_W-1:0] sample;
    logic              last;
    logic [FILL_W-1:0] fill;
    logic              flush;
  } ring_word_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_operation;
  logic [CNT_W-1:0]  in_request_count;
  logic [WORD_W-1:0] in_sample_in;
  logic              out_valid;
  logic [CNT_W-1:0]  out_granted_count;
  logic [WORD_W-1:0] out_sample_out;
  logic              out_last;
  logic [FILL_W-1:0] out_fill_level;
  logic              out_flush_pending;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  frame_aligned_sample_fifo dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_count(in_request_count),
    .in_sample_in(in_sample_in), .out_valid(out_valid),
    .out_granted_count(out_granted_count), .out_sample_out(out_sample_out),
    .out_last(out_last), .out_fill_level(out_fill_level),
    .out_flush_pending(out_flush_pending), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor state: our own copy of the ring, its pointers and the frame size.
  logic [WORD_W-1:0]  ring_mem [RING_DEPTH];
  logic [FILL_W-1:0]  wr_ptr, rd_ptr;
  logic               flush_flag;
  logic [CNT_W-1:0]   reserved, stored;
  logic [FRAME_W-1:0] frame_len;

  command_t   pending_cmds[$];
  ring_word_t expected_words[$];
  int         mismatches;
  bit         driver_quiet;   // no idle gaps in the final part of the run
  int         drive_gap;
  bit         config_busy;

  function automatic logic [FILL_W-1:0] ring_fill();
    return wr_ptr - rd_ptr;
  endfunction

  // Clamp the wanted count to the room, then round a short take to whole frames.
  function automatic int frame_grant(int wanted, int room);
    int take, flen;
    take = (wanted < room) ? wanted : room;
    flen = (frame_len == 0) ? 1 : ((frame_len > FRAME_MAX) ? FRAME_MAX : frame_len);
    if (take >= wanted || flen < 2) return take;
    return take - (take % flen);
  endfunction

  function automatic void push_word(int granted, logic [WORD_W-1:0] smp, logic lst);
    ring_word_t w;
    w.granted = CNT_W'(granted);
    w.sample  = smp;
    w.last    = lst;
    w.fill    = ring_fill();
    w.flush   = flush_flag;
    expected_words.push_back(w);
  endfunction

  // Work out every result one accepted command causes and update the ring copy.
  function automatic void predict_ring(command_t c);
    int cnt, take, g;
    logic [FILL_W-1:0] base;
    cnt = (c.count > BURST_MAX) ? BURST_MAX : c.count;
    case (c.op)
      OP_WR_REQ: begin
        if (reserved != 0) begin
          push_word(0, '0, 1'b1);
        end else begin
          take = frame_grant(cnt, RING_DEPTH - 1 - ring_fill());
          reserved = CNT_W'(take);
          stored = '0;
          push_word(take, '0, 1'b1);
        end
      end
      OP_WR_SMP: begin
        if (reserved == 0) begin
          push_word(0, '0, 1'b1);
        end else begin
          g = reserved;
          ring_mem[wr_ptr + stored] = c.sample;
          stored++;
          if (stored >= reserved) begin
            wr_ptr = wr_ptr + reserved;
            reserved = '0;
            stored = '0;
          end
          push_word(g, '0, 1'b1);
        end
      end
      OP_RD_REQ: begin
        if (reserved != 0) begin
          push_word(0, '0, 1'b1);
        end else if (flush_flag) begin
          rd_ptr = wr_ptr;
          flush_flag = 1'b0;
          push_word(0, '0, 1'b1);
        end else begin
          take = frame_grant(cnt, ring_fill());
          if (take == 0) begin
            push_word(0, '0, 1'b1);
          end else begin
            base = rd_ptr;
            rd_ptr = rd_ptr + FILL_W'(take);
            for (int i = 0; i < take; i++) begin
              push_word(take, ring_mem[FILL_W'(base + i)], i + 1 == take);
            end
          end
        end
      end
      OP_FLUSH: begin
        flush_flag = 1'b1;
        push_word(0, '0, 1'b1);
      end
      OP_CLEAR: begin
        rd_ptr = wr_ptr;
        flush_flag = 1'b0;
        push_word(0, '0, 1'b1);
      end
      default: push_word(0, '0, 1'b1);
    endcase
  endfunction

  // Driver: takes commands from the pending queue, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n || config_busy) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Command still waiting to be taken; hold it.
    end else begin
      if (start) predict_ring('{in_operation, in_request_count, in_sample_in});
      if (drive_gap > 0) begin
        drive_gap <= drive_gap - 1;
        start <= 1'b0;
      end else if (!driver_quiet && $urandom_range(0, 9) == 0) begin
        drive_gap <= $urandom_range(1, 14) - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        command_t c;
        c = pending_cmds.pop_front();
        in_operation     <= c.op;
        in_request_count <= c.count;
        in_sample_in     <= c.sample;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ring_word_t got, want;
      got = '{out_granted_count, out_sample_out, out_last, out_fill_level,
              out_flush_pending};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write the frame size through the APB port: setup, then access.
  task automatic write_frame_len(logic [FRAME_W-1:0] value);
    wait_drained();
    config_busy = 1'b1;
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_FRAME_SIZE, 2'b00}; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    frame_len = value;
    config_busy = 1'b0;
  endtask

  function automatic void add_cmd(logic [2:0] op, int count, logic [WORD_W-1:0] smp);
    pending_cmds.push_back('{op, CNT_W'(count), smp});
  endfunction

  // A write: request, then as many samples as requested; samples beyond the
  // grant arrive as stray samples and are harmless.
  function automatic void add_write_burst(int count);
    add_cmd(OP_WR_REQ, count, $urandom());
    for (int i = 0; i < count; i++) add_cmd(OP_WR_SMP, 0, $urandom());
  endfunction

  initial begin
    int pick;
    rst_n = 1'b0; start = 1'b0; in_operation = '0; in_request_count = '0;
    in_sample_in = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0;
    pwdata = '0; mismatches = 0; driver_quiet = 0; drive_gap = 0; config_busy = 0;
    wr_ptr = '0; rd_ptr = '0; flush_flag = 0; reserved = '0; stored = '0; frame_len = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme words, oversized counts, refusal, stray sample,
    // flush on read, clear under reservation, unknown code.
    add_cmd(OP_WR_SMP, 0, 32'hdead_beef);
    add_cmd(OP_RD_REQ, 5, '0);
    add_cmd(OP_WR_REQ, 3, '0);
    add_cmd(OP_RD_REQ, 3, '0);
    add_cmd(OP_WR_REQ, 3, '0);
    add_cmd(OP_WR_SMP, 0, 32'hffff_ffff);
    add_cmd(OP_CLEAR, 0, '0);
    add_cmd(OP_WR_SMP, 0, 32'h0000_0000);
    add_cmd(OP_WR_SMP, 0, 32'h8000_0001);
    add_cmd(OP_RD_REQ, 127, '0);
    add_cmd(OP_WR_REQ, 127, '0);
    add_cmd(OP_FLUSH, 0, '0);
    add_cmd(OP_CLEAR, 0, '0);
    add_cmd(OP_BAD, 127, 32'h5555_aaaa);
    add_cmd(3'd5, 1, '0);
    add_cmd(3'd6, 64, '0);
    wait_drained();
    // Finish the 64-sample reservation, then flush and read.
    for (int i = 0; i < 64; i++) add_cmd(OP_WR_SMP, 0, $urandom());
    add_cmd(OP_FLUSH, 0, '0);
    add_cmd(OP_RD_REQ, 4, '0);
    add_cmd(OP_RD_REQ, 4, '0);

    // Random phases over several frame sizes, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      logic [FRAME_W-1:0] fl;
      case (phase)
        0: fl = 0;
        1: fl = 31;
        2: fl = 16;
        3: fl = 1;
        default: fl = $urandom_range(2, 15);
      endcase
      write_frame_len(fl);
      if (phase == 5) driver_quiet = 1;
      for (int n = 0; n < 45; ) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          pick = $urandom_range(0, 9) == 0 ? $urandom_range(65, 127) : $urandom_range(0, 20);
          if (pick > BURST_MAX) pick = BURST_MAX;
          add_write_burst(pick);
          n += pick;
        end else if (pick < 15) begin
          add_cmd(OP_RD_REQ, $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 24), '0);
        end else if (pick == 15) begin
          add_cmd(OP_FLUSH, 0, '0);
        end else if (pick == 16) begin
          add_cmd(OP_CLEAR, 0, '0);
        end else if (pick == 17) begin
          add_cmd(OP_WR_SMP, 0, $urandom());
        end else begin
          add_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 127), $urandom());
        end
        n++;
      end
    end
    wait_drained();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== frame_aligned_sample_fifo.f =====
+incdir+src
src/fasf_pkg.sv
src/fasf_queue.sv
src/fasf_front.sv
src/fasf_back.sv
src/frame_aligned_sample_fifo.sv
src/fasf_checker.sv
tb/tb.sv
